// ----- design/lsd_pkg.sv -----
// Shared types and constants for the LSB stego frame decoder.
package lsd_pkg;

  localparam int MWORD_W = 40;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 64;
  localparam int REG_SEL = 3;

  localparam logic       REG_MAGIC = 1'b0;
  localparam logic       REG_HDR   = 1'b1;
  localparam logic [7:0] HDR_RESET = 8'd54;

  localparam logic [4:0] WORD_LAST = 5'd31;
  localparam logic [4:0] BYTE_LAST = 5'd7;

  localparam logic [2:0] KIND_EXT      = 3'd0;
  localparam logic [2:0] KIND_PAY      = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_TOOLONG  = 3'd4;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_MAGIC,
    PH_EXTLEN,
    PH_EXT,
    PH_PAYLEN,
    PH_PAY,
    PH_DONE
  } ph_t;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] kind;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [MWORD_W-1:0] magic_word;
    logic [7:0]         header_offset;
  } cfg_t;

endpackage

// ----- design/lsd_ifs.sv -----
// Valid/ready channel interfaces for image bytes and decoded results.
interface lsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cover_byte;
  logic       restart;

  modport source (output valid, output cover_byte, output restart, input ready);
  modport sink   (input valid, input cover_byte, input restart, output ready);
endinterface

interface lsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value;
  logic [2:0] kind;
  logic       last;

  modport source (output valid, output value, output kind, output last, input ready);
  modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

// ----- design/lsd_cfg.sv -----
// APB register file: magic word and header offset.
module lsd_cfg
  import lsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MWORD_W-1:0] magic_r;
  logic [7:0]         hoff_r;
  logic               wr_en;
  logic               sel;

  assign pready = 1'b1;
  assign sel    = paddr[REG_SEL];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
      hoff_r  <= HDR_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_MAGIC: magic_r <= pwdata[MWORD_W-1:0];
        REG_HDR:   hoff_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MAGIC: prdata = {{(APB_DW-MWORD_W){1'b0}}, magic_r};
      REG_HDR:   prdata = {{(APB_DW-8){1'b0}}, hoff_r};
      default:   prdata = '0;
    endcase
  end

  assign cfg.magic_word    = magic_r;
  assign cfg.header_offset = hoff_r;

endmodule

// ----- design/lsd_core.sv -----
// Per-byte decode: header skip, bit gathering, field sequencing, result.
module lsd_core
  import lsd_pkg::*;
#(
  parameter int MAGIC_LEN   = 5,
  parameter int MAX_EXT_LEN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic [7:0] in_cover_byte,
  input  logic       in_restart,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam int MW  = 8 * MAGIC_LEN;
  localparam int MIW = (MAGIC_LEN > 1) ? $clog2(MAGIC_LEN) : 1;

  ph_t            ph_r, ph_nxt, eff_ph, ph_w;
  logic [7:0]     hc_r, hc_nxt, eff_hc;
  logic [4:0]     bi_r, bi_nxt, eff_bi;
  logic [31:0]    sw_r, sw_nxt, eff_sw, sw_sh;
  logic [MW-1:0]  ma_r, ma_nxt, eff_ma, ma_sh, magic_exp;
  logic [MIW-1:0] mi_r, mi_nxt, eff_mi;
  logic [30:0]    rem_r, rem_nxt, eff_rem, len_val, rem_dec;
  logic           skipping, full32, full8, magic_ok, fin, magic_end, too_long;
  logic [7:0]     byte_val;

  generate
    if (MW <= MWORD_W) begin : g_mnarrow
      assign magic_exp = cfg.magic_word[MW-1:0];
    end else begin : g_mwide
      assign magic_exp = {{(MW-MWORD_W){1'b0}}, cfg.magic_word};
    end
  endgenerate

  // restart drops the state back to reset before this byte is processed
  assign eff_ph  = in_restart ? PH_SKIP : ph_r;
  assign eff_hc  = in_restart ? '0 : hc_r;
  assign eff_bi  = in_restart ? '0 : bi_r;
  assign eff_sw  = in_restart ? '0 : sw_r;
  assign eff_ma  = in_restart ? '0 : ma_r;
  assign eff_mi  = in_restart ? '0 : mi_r;
  assign eff_rem = in_restart ? '0 : rem_r;

  assign skipping  = (eff_ph == PH_SKIP) && (eff_hc < cfg.header_offset);
  assign ph_w      = (eff_ph == PH_SKIP) ? PH_MAGIC : eff_ph;
  assign sw_sh     = {eff_sw[30:0], in_cover_byte[0]};
  assign full32    = (eff_bi == WORD_LAST);
  assign full8     = (eff_bi == BYTE_LAST);
  assign len_val   = sw_sh[31] ? '0 : sw_sh[30:0];
  assign too_long  = (len_val > 31'(MAX_EXT_LEN));
  assign byte_val  = sw_sh[7:0];
  assign ma_sh     = MW'({eff_ma, byte_val});
  assign magic_ok  = (ma_sh == magic_exp);
  assign magic_end = (eff_mi == MIW'(MAGIC_LEN - 1));
  assign rem_dec   = (eff_rem != '0) ? eff_rem - 31'd1 : '0;
  assign fin       = (rem_dec == '0);

  // next state
  always_comb begin
    ph_nxt  = eff_ph;
    hc_nxt  = eff_hc;
    bi_nxt  = eff_bi;
    sw_nxt  = eff_sw;
    ma_nxt  = eff_ma;
    mi_nxt  = eff_mi;
    rem_nxt = eff_rem;
    if (skipping) begin
      hc_nxt = eff_hc + 8'd1;
    end else begin
      ph_nxt = ph_w;
      case (ph_w)
        PH_EXTLEN, PH_PAYLEN: begin
          if (!full32) begin
            bi_nxt = eff_bi + 5'd1;
            sw_nxt = sw_sh;
          end else begin
            bi_nxt  = '0;
            sw_nxt  = '0;
            rem_nxt = len_val;
            if (ph_w == PH_EXTLEN) begin
              if (too_long)               ph_nxt = PH_DONE;
              else if (len_val == '0)     ph_nxt = PH_PAYLEN;
              else                        ph_nxt = PH_EXT;
            end else begin
              ph_nxt = (len_val == '0) ? PH_DONE : PH_PAY;
            end
          end
        end
        PH_MAGIC, PH_EXT, PH_PAY: begin
          if (!full8) begin
            bi_nxt = eff_bi + 5'd1;
            sw_nxt = sw_sh;
          end else begin
            bi_nxt = '0;
            sw_nxt = '0;
            if (ph_w == PH_MAGIC) begin
              ma_nxt = ma_sh;
              if (magic_end) begin
                mi_nxt = '0;
                ph_nxt = magic_ok ? PH_EXTLEN : PH_DONE;
              end else begin
                mi_nxt = eff_mi + MIW'(1);
              end
            end else begin
              rem_nxt = rem_dec;
              if (fin) ph_nxt = (ph_w == PH_EXT) ? PH_PAYLEN : PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (!skipping) begin
      case (ph_w)
        PH_EXTLEN: begin
          if (full32 && too_long) begin
            res_valid = 1'b1;
            res.kind  = KIND_TOOLONG;
            res.last  = 1'b1;
          end
        end
        PH_PAYLEN: begin
          if (full32 && (len_val == '0)) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end
        end
        PH_MAGIC: begin
          if (full8 && magic_end && !magic_ok) begin
            res_valid = 1'b1;
            res.kind  = KIND_MISMATCH;
            res.last  = 1'b1;
          end
        end
        PH_EXT, PH_PAY: begin
          if (full8) begin
            res_valid = 1'b1;
            res.value = byte_val;
            res.kind  = (ph_w == PH_EXT) ? KIND_EXT : KIND_PAY;
            res.last  = fin;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_SKIP;
      hc_r  <= '0;
      bi_r  <= '0;
      sw_r  <= '0;
      ma_r  <= '0;
      mi_r  <= '0;
      rem_r <= '0;
    end else if (in_acc) begin
      ph_r  <= ph_nxt;
      hc_r  <= hc_nxt;
      bi_r  <= bi_nxt;
      sw_r  <= sw_nxt;
      ma_r  <= ma_nxt;
      mi_r  <= mi_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- design/lsd_outq.sv -----
// Two-entry result queue: output register plus skid slot.
module lsd_outq
  import lsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  input  logic pop_ready,
  output logic pop_valid,
  output res_t pop_res,
  output logic has_room
);

  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_FULL  = 2'd2;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       head_r, head_nxt, tail_r, tail_nxt;
  logic       pop;

  assign pop_valid = (cnt_r != CNT_EMPTY);
  assign pop_res   = head_r;
  assign has_room  = (cnt_r != CNT_FULL);
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    case ({push, pop})
      2'b11: begin
        if (cnt_r == CNT_ONE) begin
          head_nxt = push_res;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_res;
        end
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b10: begin
        if (cnt_r == CNT_EMPTY) head_nxt = push_res;
        else                    tail_nxt = push_res;
        cnt_nxt = cnt_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= CNT_EMPTY;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ----- design/lsb_stego_frame_decoder.sv -----
// Top level of the LSB stego frame decoder.
//
//  beat      dir  width        carries
//  in_if     in   8+1          cover_byte, restart
//  out_if    out  8+3+1        value, kind, last
//  APB       in   64 data      magic_word @0x0, header_offset @0x8
//
// One image byte per cycle while the queue has room; results leave from its head.
// Decode is one combinational pass from the accepted byte into state and queue.
// A two-entry result queue lets input continue while one result is stalled;
// in_if.ready drops only when both entries are held.
// Synchronous active-low reset; no clearing pass.
module lsb_stego_frame_decoder
  import lsd_pkg::*;
#(
  parameter int MAGIC_LEN   = 5,
  parameter int MAX_EXT_LEN = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  lsd_in_if.sink            in_if,
  lsd_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t res, out_res;
  logic res_valid, in_acc, has_room;

  assign in_if.ready = has_room;
  assign in_acc      = in_if.valid && has_room;

  lsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lsd_core #(
    .MAGIC_LEN   (MAGIC_LEN),
    .MAX_EXT_LEN (MAX_EXT_LEN)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .in_cover_byte (in_if.cover_byte),
    .in_restart    (in_if.restart),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  lsd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && res_valid),
    .push_res  (res),
    .pop_ready (out_if.ready),
    .pop_valid (out_if.valid),
    .pop_res   (out_res),
    .has_room  (has_room)
  );

  assign out_if.value = out_res.value;
  assign out_if.kind  = out_res.kind;
  assign out_if.last  = out_res.last;

endmodule

// ----- design/lsd_checker.sv -----
// Port-level assertions for the decoder, bound to the top level.
module lsd_checker
  import lsd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_value,
  input logic [2:0] out_kind,
  input logic       out_last
);

  logic is_status;
  assign is_status = (out_kind == KIND_EMPTY) || (out_kind == KIND_MISMATCH) ||
                     (out_kind == KIND_TOOLONG);

  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result present right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_TOOLONG))
    else $error("undefined result kind");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_status |-> out_last && (out_value == 8'd0))
    else $error("status result not last or nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
                                $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind lsb_stego_frame_decoder lsd_checker u_lsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.value),
  .out_kind  (out_if.kind),
  .out_last  (out_if.last)
);
